// ----- design/p256mm_pkg.sv -----
// Shared types and constants for the P-256 Montgomery multiplier.
// Used by p256mm_round and p256_montgomery_multiply_top; no dependencies.
package p256mm_pkg;
	localparam int LIMBS = 4;
	localparam int LIMB_W = 64;
	localparam int HALF_W = 32;
	localparam int FE_W = LIMBS * LIMB_W;
	localparam int ACC_W = FE_W + 2;
	localparam int T_W = FE_W + LIMB_W + 2;
	localparam int ROUND_STAGES = 4;
	localparam int LATENCY = LIMBS * ROUND_STAGES + 1;
	localparam logic [FE_W-1:0] PRIME =
		256'hFFFFFFFF00000001_0000000000000000_00000000FFFFFFFF_FFFFFFFFFFFFFFFF;

	typedef struct packed {
		logic [FE_W-1:0]  a;
		logic [FE_W-1:0]  b;
		logic [ACC_W-1:0] acc;
	} word_t;
endpackage

// ----- design/p256_montgomery_multiply_top.sv -----
// Top level of the pipelined P-256 Montgomery multiplier.
// Instantiates four p256mm_round stages and the final subtraction; uses p256mm_pkg.
//
// Usage: drive a_limb0..3 and b_limb0..3 with start high; a word is taken at
// every clock edge where start is high and busy is low. busy stays low, so a
// new word may enter in every cycle (throughput one word per cycle).
// Each word returns r = a*b*2^-256 mod p on r_limb0..3, marked by done
// for one cycle. The pipeline is four CIOS iterations of four stages each
// (32x32 partial products, limb product sums, accumulation, reduction by p)
// plus one stage for the conditional subtraction of p. Results leave in the
// order words entered. The receiver cannot stall, so results are never held back.
// Reset clears all valid bits; words in flight are dropped and done stays low.
module p256_montgomery_multiply_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] a_limb0,
	input  logic [63:0] a_limb1,
	input  logic [63:0] a_limb2,
	input  logic [63:0] a_limb3,
	input  logic [63:0] b_limb0,
	input  logic [63:0] b_limb1,
	input  logic [63:0] b_limb2,
	input  logic [63:0] b_limb3,
	output logic        done,
	output logic [63:0] r_limb0,
	output logic [63:0] r_limb1,
	output logic [63:0] r_limb2,
	output logic [63:0] r_limb3
);
	localparam int NL = p256mm_pkg::LIMBS;
	localparam int AW = p256mm_pkg::ACC_W;
	localparam int FW = p256mm_pkg::FE_W;

	logic valid_c [NL+1];
	p256mm_pkg::word_t word_c [NL+1];
	logic [AW-1:0] acc_f;
	logic [AW-1:0] diff_f;
	logic done_q;
	logic [FW-1:0] r_q;

	assign busy = 1'b0;
	assign valid_c[0] = start & ~busy;
	assign word_c[0].a = {a_limb3, a_limb2, a_limb1, a_limb0};
	assign word_c[0].b = {b_limb3, b_limb2, b_limb1, b_limb0};
	assign word_c[0].acc = '0;

	for (genvar i = 0; i < NL; i++) begin : g_round
		p256mm_round #(.LIMB_IDX(i)) u_round (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (valid_c[i]),
			.in_word  (word_c[i]),
			.out_valid(valid_c[i+1]),
			.out_word (word_c[i+1])
		);
	end

	assign acc_f = word_c[NL].acc;
	assign diff_f = acc_f - AW'(p256mm_pkg::PRIME);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_c[NL];
		end
	end

	always_ff @(posedge clk) begin
		if (acc_f >= AW'(p256mm_pkg::PRIME)) begin
			r_q <= diff_f[FW-1:0];
		end else begin
			r_q <= acc_f[FW-1:0];
		end
	end

	assign done = done_q;
	assign r_limb0 = r_q[63:0];
	assign r_limb1 = r_q[127:64];
	assign r_limb2 = r_q[191:128];
	assign r_limb3 = r_q[255:192];

	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start & ~busy, p256mm_pkg::LATENCY))
		else $error("Result strobe without a word taken 17 cycles earlier.");

	a_no_lost_word: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(start & ~busy, p256mm_pkg::LATENCY) |-> !done)
		else $error("Result strobe does not match the pipeline latency.");

	a_round_valid: assert property (@(posedge clk) disable iff (!arst_n)
		valid_c[NL] |=> done)
		else $error("Last round output did not reach the result register.");
endmodule

// ----- design/p256mm_round.sv -----
// One CIOS iteration as four pipeline stages: partial products, limb products,
// accumulation of a_i*b, and the shift-add reduction by p. Depends on p256mm_pkg.
module p256mm_round #(
	parameter int LIMB_IDX = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  p256mm_pkg::word_t     in_word,
	output logic                  out_valid,
	output p256mm_pkg::word_t     out_word
);
	localparam int LW = p256mm_pkg::LIMB_W;
	localparam int HW = p256mm_pkg::HALF_W;
	localparam int NL = p256mm_pkg::LIMBS;
	localparam int TW = p256mm_pkg::T_W;
	localparam int AW = p256mm_pkg::ACC_W;

	logic [3:0] valid_q;
	p256mm_pkg::word_t word_s1, word_s2, word_s3, word_s4;
	logic [LW-1:0] pp_s1 [NL][4];
	logic [2*LW-1:0] prod_s2 [NL];
	logic [TW-1:0] t_s3;
	logic [LW-1:0] a_limb;
	logic [TW-1:0] t_sum;
	logic [TW-1:0] m_w;
	logic [TW-1:0] red_sum;

	assign a_limb = in_word.a[LIMB_IDX*LW +: LW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= {valid_q[2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		word_s1 <= in_word;
		for (int j = 0; j < NL; j++) begin
			pp_s1[j][0] <= LW'(a_limb[HW-1:0]) * LW'(in_word.b[j*LW +: HW]);
			pp_s1[j][1] <= LW'(a_limb[HW-1:0]) * LW'(in_word.b[j*LW+HW +: HW]);
			pp_s1[j][2] <= LW'(a_limb[LW-1:HW]) * LW'(in_word.b[j*LW +: HW]);
			pp_s1[j][3] <= LW'(a_limb[LW-1:HW]) * LW'(in_word.b[j*LW+HW +: HW]);
		end
	end

	always_ff @(posedge clk) begin
		word_s2 <= word_s1;
		for (int j = 0; j < NL; j++) begin
			prod_s2[j] <= (2*LW)'(pp_s1[j][0])
				+ ((2*LW)'(pp_s1[j][1]) << HW)
				+ ((2*LW)'(pp_s1[j][2]) << HW)
				+ ((2*LW)'(pp_s1[j][3]) << LW);
		end
	end

	always_comb begin
		t_sum = TW'(word_s2.acc);
		for (int j = 0; j < NL; j++) begin
			t_sum = t_sum + (TW'(prod_s2[j]) << (j*LW));
		end
	end

	always_ff @(posedge clk) begin
		word_s3 <= word_s2;
		t_s3 <= t_sum;
	end

	assign m_w = TW'(t_s3[LW-1:0]);
	assign red_sum = t_s3 + (m_w << 256) + (m_w << 192) + (m_w << 96)
		- (m_w << 224) - m_w;

	always_ff @(posedge clk) begin
		word_s4.a <= word_s3.a;
		word_s4.b <= word_s3.b;
		word_s4.acc <= red_sum[LW +: AW];
	end

	assign out_valid = valid_q[3];
	assign out_word = word_s4;
endmodule

// ----- verif/p256_montgomery_multiply_top_tb.sv -----
// Testbench for p256_montgomery_multiply_top: drives operand words, predicts each
// Montgomery product with wide integer arithmetic, and checks every result limb.
// Depends on p256mm_pkg and the design files under design/.
`timescale 1ns / 100ps

module p256_montgomery_multiply_top_tb;

	typedef struct {
		logic [63:0] limb0;
		logic [63:0] limb1;
		logic [63:0] limb2;
		logic [63:0] limb3;
	} product_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [63:0] a_limb0, a_limb1, a_limb2, a_limb3;
	logic [63:0] b_limb0, b_limb1, b_limb2, b_limb3;
	logic        done;
	logic [63:0] r_limb0, r_limb1, r_limb2, r_limb3;

	product_t pending_products[$];
	int       error_count = 0;
	int       cycle_count = 0;
	bit       idle_enable = 0;

	p256_montgomery_multiply_top DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.a_limb0(a_limb0), .a_limb1(a_limb1), .a_limb2(a_limb2), .a_limb3(a_limb3),
		.b_limb0(b_limb0), .b_limb1(b_limb1), .b_limb2(b_limb2), .b_limb3(b_limb3),
		.done(done),
		.r_limb0(r_limb0), .r_limb1(r_limb1), .r_limb2(r_limb2), .r_limb3(r_limb3)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic product_t montgomery_product(logic [255:0] a, logic [255:0] b);
		logic [383:0] t;
		logic [319:0] acc;
		logic [319:0] diff;
		logic [63:0]  m;
		product_t     r;
		acc = '0;
		for (int i = 0; i < p256mm_pkg::LIMBS; i++) begin
			t = {64'd0, acc} + {128'd0, b} * {320'd0, a[i*64 +: 64]};
			m = t[63:0];
			t = t + {128'd0, p256mm_pkg::PRIME} * {320'd0, m};
			acc = t[383:64];
		end
		diff = acc - {64'd0, p256mm_pkg::PRIME};
		if (acc >= {64'd0, p256mm_pkg::PRIME})
			acc = diff;
		r.limb0 = acc[63:0];
		r.limb1 = acc[127:64];
		r.limb2 = acc[191:128];
		r.limb3 = acc[255:192];
		return r;
	endfunction

	function automatic logic [63:0] pick_limb(int idx);
		logic [63:0] v;
		case ($urandom_range(0, 9))
			0: v = '0;
			1: v = '1;
			2: v = p256mm_pkg::PRIME[idx*64 +: 64];
			3: v = p256mm_pkg::PRIME[idx*64 +: 64] - 64'd1;
			4: v = 64'd1 << $urandom_range(0, 63);
			default: v = {$urandom, $urandom};
		endcase
		return v;
	endfunction

	function automatic logic [255:0] pick_operand();
		logic [255:0] v;
		for (int k = 0; k < p256mm_pkg::LIMBS; k++)
			v[k*64 +: 64] = pick_limb(k);
		return v;
	endfunction

	task automatic send_word(logic [255:0] a, logic [255:0] b);
		int gap;
		start   <= 1'b1;
		a_limb0 <= a[63:0];
		a_limb1 <= a[127:64];
		a_limb2 <= a[191:128];
		a_limb3 <= a[255:192];
		b_limb0 <= b[63:0];
		b_limb1 <= b[127:64];
		b_limb2 <= b[191:128];
		b_limb3 <= b[255:192];
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_products.push_back(montgomery_product(a, b));
		if (idle_enable && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 17);
			start <= 1'b0;
			repeat (gap - 1)
				@(posedge clk);
			@(posedge clk);
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (pending_products.size() != 0)
			@(posedge clk);
		repeat (p256mm_pkg::LATENCY + 4)
			@(posedge clk);
	endtask

	task automatic test_directed();
		logic [255:0] p_minus_1;
		logic [255:0] ones;
		p_minus_1 = p256mm_pkg::PRIME - 256'd1;
		ones = '1;
		send_word('0, '0);
		send_word(256'd1, 256'd1);
		send_word(ones, ones);
		send_word(p256mm_pkg::PRIME, p256mm_pkg::PRIME);
		send_word(p_minus_1, p_minus_1);
		send_word(p_minus_1, 256'd1);
		send_word(p256mm_pkg::PRIME, ones);
		send_word(ones, 256'd0);
		send_word(256'd1 << 255, ones);
		send_word(~p256mm_pkg::PRIME + 256'd1, 256'd1);
		send_word(p_minus_1, ones);
		send_word(256'd2, p_minus_1);
		send_word({4{64'hAAAAAAAAAAAAAAAA}}, {4{64'h5555555555555555}});
		send_word({4{64'h5555555555555555}}, {4{64'hAAAAAAAAAAAAAAAA}});
	endtask

	task automatic test_random_idle();
		idle_enable = 1;
		for (int n = 0; n < 450; n++)
			send_word(pick_operand(), pick_operand());
	endtask

	task automatic test_pause_drain();
		send_word(pick_operand(), pick_operand());
		wait_drained();
	endtask

	task automatic test_back_to_back();
		idle_enable = 0;
		for (int n = 0; n < 100; n++)
			send_word(pick_operand(), pick_operand());
	endtask

	always @(posedge clk) begin
		product_t exp_r;
		if (arst_n && done) begin
			if (pending_products.size() == 0) begin
				$error("unexpected result word");
				error_count++;
			end else begin
				exp_r = pending_products.pop_front();
				if (r_limb0 !== exp_r.limb0) begin
					$error("r_limb0 expected %h actual %h", exp_r.limb0, r_limb0);
					error_count++;
				end
				if (r_limb1 !== exp_r.limb1) begin
					$error("r_limb1 expected %h actual %h", exp_r.limb1, r_limb1);
					error_count++;
				end
				if (r_limb2 !== exp_r.limb2) begin
					$error("r_limb2 expected %h actual %h", exp_r.limb2, r_limb2);
					error_count++;
				end
				if (r_limb3 !== exp_r.limb3) begin
					$error("r_limb3 expected %h actual %h", exp_r.limb3, r_limb3);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > 200000) begin
			$display("p256_montgomery_multiply_top test failed");
			$finish;
		end
	end

	initial begin
		arst_n  = 1'b0;
		start   = 1'b0;
		a_limb0 = '0;
		a_limb1 = '0;
		a_limb2 = '0;
		a_limb3 = '0;
		b_limb0 = '0;
		b_limb1 = '0;
		b_limb2 = '0;
		b_limb3 = '0;
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_pause_drain();
		test_random_idle();
		test_pause_drain();
		test_back_to_back();
		wait_drained();
		if (error_count == 0)
			$display("p256_montgomery_multiply_top test passed");
		else
			$display("p256_montgomery_multiply_top test failed");
		$finish;
	end
endmodule
